FILE: hdl/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// Types and constants for the two-process CPU scheduler core.
// ----------------------------------------------------------------------------
package tpcs_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;
   localparam int CFG_BURST_BITS = 10;
   localparam int SLICE_CFG_BITS = 8;
   localparam int SLICE_BITS     = 16;

   typedef enum logic [1:0] {
      ST_READY = 2'd0,
      ST_RUN   = 2'd1,
      ST_WAIT  = 2'd2,
      ST_DONE  = 2'd3
   } proc_state_type;

   typedef enum logic [1:0] {
      MODE_FCFS = 2'd0,
      MODE_SJF  = 2'd1,
      MODE_PSJF = 2'd2,
      MODE_RR   = 2'd3
   } policy_mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POLICY_MODE  = 3'd0,
      CSR_TIME_SLICE   = 3'd1,
      CSR_FIRST_CPU_A  = 3'd2,
      CSR_IO_A         = 3'd3,
      CSR_SECOND_CPU_A = 3'd4,
      CSR_FIRST_CPU_B  = 3'd5,
      CSR_IO_B         = 3'd6,
      CSR_SECOND_CPU_B = 3'd7
   } csr_index_type;

endpackage

FILE: hdl/two_process_cpu_scheduler_core.sv
// ----------------------------------------------------------------------------
// two_process_cpu_scheduler_core
// Steps a two-process scheduler (FCFS, SJF, preemptive SJF, round robin)
// one tick per request beat and reports states and run statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req_restart): one beat is one
//   scheduler tick; req_restart reloads the bursts and clears the counts
//   before the tick runs.
//   Response channel (rsp_valid, rsp_stall, rsp_*): one beat per request
//   beat, in order, carrying both process states and the saturating counts.
//   CSR port (csr_wr_en, csr_index, csr_wr_data): write policy, quantum and
//   burst lengths while no request is in flight; no read-back.
// Timing:
//   The tick is computed combinationally from the state registers into the
//   response register, so a response follows in the cycle after its request;
//   one beat is taken every cycle while req_stall is low.
// Reset:
//   Synchronous, active high. Config returns to mode 0, quantum 1, all
//   bursts 1; both processes are ready and all counts are zero.
// Stall:
//   While rsp_stall holds a waiting response, req_stall is raised and the
//   response payload holds.
// ----------------------------------------------------------------------------
module two_process_cpu_scheduler_core
   import tpcs_pkg::*;
#(
   parameter int BURST_BITS = 10,
   parameter int STAT_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_state_a,
   output logic [1:0]                rsp_state_b,
   output logic [STAT_BITS-1:0]      rsp_ready_ticks_a,
   output logic [STAT_BITS-1:0]      rsp_ready_ticks_b,
   output logic [STAT_BITS-1:0]      rsp_busy_ticks,
   output logic [STAT_BITS-1:0]      rsp_run_length,
   output logic                      rsp_finished
);

   policy_mode_type            mode_ff;
   logic [SLICE_CFG_BITS-1:0]  time_slice_ff;
   logic [CFG_BURST_BITS-1:0]  first_cpu_a_ff, io_a_ff, second_cpu_a_ff;
   logic [CFG_BURST_BITS-1:0]  first_cpu_b_ff, io_b_ff, second_cpu_b_ff;

   proc_state_type             state_a_ff, state_b_ff, state_a_in, state_b_in;
   logic [BURST_BITS-1:0]      cpu_left_a_ff, io_left_a_ff, cpu_left_b_ff, io_left_b_ff;
   logic [BURST_BITS-1:0]      cpu_left_a_in, io_left_a_in, cpu_left_b_in, io_left_b_in;
   logic [SLICE_BITS-1:0]      slice_left_ff, slice_left_in;
   logic [STAT_BITS-1:0]       wait_a_ff, wait_b_ff, busy_ff, length_ff;
   logic [STAT_BITS-1:0]       wait_a_in, wait_b_in, busy_in, length_in;
   logic                       finished_in;

   logic                       rsp_valid_ff;
   proc_state_type             rsp_state_a_ff, rsp_state_b_ff;
   logic [STAT_BITS-1:0]       rsp_wait_a_ff, rsp_wait_b_ff, rsp_busy_ff, rsp_length_ff;
   logic                       rsp_finished_ff;

   logic                       req_accept;

   function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] v);
      sat_inc = (v == {STAT_BITS{1'b1}}) ? v : v + STAT_BITS'(1);
   endfunction

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_FCFS;
         time_slice_ff   <= SLICE_CFG_BITS'(1);
         first_cpu_a_ff  <= CFG_BURST_BITS'(1);
         io_a_ff         <= CFG_BURST_BITS'(1);
         second_cpu_a_ff <= CFG_BURST_BITS'(1);
         first_cpu_b_ff  <= CFG_BURST_BITS'(1);
         io_b_ff         <= CFG_BURST_BITS'(1);
         second_cpu_b_ff <= CFG_BURST_BITS'(1);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_POLICY_MODE:  mode_ff         <= policy_mode_type'(csr_wr_data[1:0]);
            CSR_TIME_SLICE:   time_slice_ff   <= csr_wr_data[SLICE_CFG_BITS-1:0];
            CSR_FIRST_CPU_A:  first_cpu_a_ff  <= csr_wr_data[CFG_BURST_BITS-1:0];
            CSR_IO_A:         io_a_ff         <= csr_wr_data[CFG_BURST_BITS-1:0];
            CSR_SECOND_CPU_A: second_cpu_a_ff <= csr_wr_data[CFG_BURST_BITS-1:0];
            CSR_FIRST_CPU_B:  first_cpu_b_ff  <= csr_wr_data[CFG_BURST_BITS-1:0];
            CSR_IO_B:         io_b_ff         <= csr_wr_data[CFG_BURST_BITS-1:0];
            CSR_SECOND_CPU_B: second_cpu_b_ff <= csr_wr_data[CFG_BURST_BITS-1:0];
            default: ;
         endcase
      end
   end

   // one scheduler tick
   always_comb begin : tick_logic
      proc_state_type        sa, sb;
      logic [BURST_BITS-1:0] ca, ia, cb, ib;
      logic [SLICE_BITS-1:0] sl;
      logic [STAT_BITS-1:0]  wa, wb, bc, lc;
      logic [SLICE_BITS-1:0] reload;
      logic                  rr, sj;

      rr     = (mode_ff == MODE_RR);
      sj     = (mode_ff == MODE_SJF) || (mode_ff == MODE_PSJF);
      reload = SLICE_BITS'(time_slice_ff);

      if (req_restart) begin
         sa = ST_READY;
         sb = ST_READY;
         ca = BURST_BITS'(first_cpu_a_ff);
         ia = BURST_BITS'(io_a_ff);
         cb = BURST_BITS'(first_cpu_b_ff);
         ib = BURST_BITS'(io_b_ff);
         sl = '0;
         wa = '0;
         wb = '0;
         bc = '0;
         lc = '0;
      end else begin
         sa = state_a_ff;
         sb = state_b_ff;
         ca = cpu_left_a_ff;
         ia = io_left_a_ff;
         cb = cpu_left_b_ff;
         ib = io_left_b_ff;
         sl = slice_left_ff;
         wa = wait_a_ff;
         wb = wait_b_ff;
         bc = busy_ff;
         lc = length_ff;
      end

      if (!(sa == ST_DONE && sb == ST_DONE)) begin
         // burst completion, process one first
         if (sa == ST_RUN && ca == '0) begin
            sa = (ia == '0) ? ST_DONE : ST_WAIT;
         end else if (sb == ST_RUN && cb == '0) begin
            sb = (ib == '0) ? ST_DONE : ST_WAIT;
         end

         // io completion loads the second burst
         if (sa == ST_WAIT && ia == '0) begin
            sa = ST_READY;
            ca = BURST_BITS'(second_cpu_a_ff);
         end
         if (sb == ST_WAIT && ib == '0) begin
            sb = ST_READY;
            cb = BURST_BITS'(second_cpu_b_ff);
         end

         // quantum expiry
         if (rr) begin
            if (sa == ST_RUN && sl == '0 && sb == ST_READY) begin
               sb = ST_RUN;
               sa = ST_READY;
               sl = reload;
            end
            if (sb == ST_RUN && sl == '0 && sa == ST_READY) begin
               sa = ST_RUN;
               sb = ST_READY;
               sl = reload;
            end
         end

         // dispatch and preemption
         if (sa == ST_READY && sb == ST_READY) begin
            if (sj && cb < ca) begin
               sb = ST_RUN;
            end else begin
               sa = ST_RUN;
            end
            if (rr) begin
               sl = reload;
            end
         end else if (sa == ST_READY && sb != ST_RUN) begin
            sa = ST_RUN;
            if (rr) begin
               sl = reload;
            end
         end else if (sb == ST_READY && sa != ST_RUN) begin
            sb = ST_RUN;
            if (rr) begin
               sl = reload;
            end
         end else if (mode_ff == MODE_PSJF) begin
            if (sa == ST_READY && ca < cb) begin
               sa = ST_RUN;
               sb = ST_READY;
            end else if (sb == ST_READY && cb < ca) begin
               sb = ST_RUN;
               sa = ST_READY;
            end
         end

         // statistics
         if (sa == ST_READY) begin
            wa = sat_inc(wa);
         end
         if (sb == ST_READY) begin
            wb = sat_inc(wb);
         end
         if (sa == ST_RUN) begin
            bc = sat_inc(bc);
         end
         if (sb == ST_RUN) begin
            bc = sat_inc(bc);
         end
         if (sa != ST_DONE || sb != ST_DONE) begin
            lc = sat_inc(lc);
         end

         // advance counters
         if (rr) begin
            sl = sl - SLICE_BITS'(1);
         end
         if (sa == ST_RUN) begin
            ca = ca - BURST_BITS'(1);
         end
         if (sa == ST_WAIT) begin
            ia = ia - BURST_BITS'(1);
         end
         if (sb == ST_RUN) begin
            cb = cb - BURST_BITS'(1);
         end
         if (sb == ST_WAIT) begin
            ib = ib - BURST_BITS'(1);
         end
      end

      state_a_in    = sa;
      state_b_in    = sb;
      cpu_left_a_in = ca;
      io_left_a_in  = ia;
      cpu_left_b_in = cb;
      io_left_b_in  = ib;
      slice_left_in = sl;
      wait_a_in     = wa;
      wait_b_in     = wb;
      busy_in       = bc;
      length_in     = lc;
      finished_in   = (sa == ST_DONE) && (sb == ST_DONE);
   end

   // scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_a_ff    <= ST_READY;
         state_b_ff    <= ST_READY;
         cpu_left_a_ff <= BURST_BITS'(1);
         io_left_a_ff  <= BURST_BITS'(1);
         cpu_left_b_ff <= BURST_BITS'(1);
         io_left_b_ff  <= BURST_BITS'(1);
         slice_left_ff <= '0;
         wait_a_ff     <= '0;
         wait_b_ff     <= '0;
         busy_ff       <= '0;
         length_ff     <= '0;
      end else if (req_accept) begin
         state_a_ff    <= state_a_in;
         state_b_ff    <= state_b_in;
         cpu_left_a_ff <= cpu_left_a_in;
         io_left_a_ff  <= io_left_a_in;
         cpu_left_b_ff <= cpu_left_b_in;
         io_left_b_ff  <= io_left_b_in;
         slice_left_ff <= slice_left_in;
         wait_a_ff     <= wait_a_in;
         wait_b_ff     <= wait_b_in;
         busy_ff       <= busy_in;
         length_ff     <= length_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_state_a_ff  <= state_a_in;
         rsp_state_b_ff  <= state_b_in;
         rsp_wait_a_ff   <= wait_a_in;
         rsp_wait_b_ff   <= wait_b_in;
         rsp_busy_ff     <= busy_in;
         rsp_length_ff   <= length_in;
         rsp_finished_ff <= finished_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_a       = rsp_state_a_ff;
   assign rsp_state_b       = rsp_state_b_ff;
   assign rsp_ready_ticks_a = rsp_wait_a_ff;
   assign rsp_ready_ticks_b = rsp_wait_b_ff;
   assign rsp_busy_ticks    = rsp_busy_ff;
   assign rsp_run_length    = rsp_length_ff;
   assign rsp_finished      = rsp_finished_ff;

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response beat");

   a_finished_matches_states: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_finished_ff ==
         ((rsp_state_a_ff == ST_DONE) && (rsp_state_b_ff == ST_DONE))))
      else $error("finished flag disagrees with process states");

   a_single_runner: assert property (@(posedge clock) disable iff (reset)
      !((state_a_ff == ST_RUN) && (state_b_ff == ST_RUN)))
      else $error("both processes running at once");

endmodule

FILE: tb/sv/two_process_cpu_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_process_cpu_scheduler_core_tb
// Self-checking bench for the two-process scheduler core. A clocked driver
// sends tick beats from a queue that the stimulus process fills phase by
// phase. Each phase first programs policy, quantum and burst lengths. A
// clocked monitor compares every response beat with the scheduler state
// that the bench itself tracks. Both sides idle at random, with one calm
// stretch and long response hold-offs that back the core up.
// ----------------------------------------------------------------------------
module two_process_cpu_scheduler_core_tb
   import tpcs_pkg::*;
();

   localparam int BURST_W     = 10;
   localparam int STAT_W      = 16;
   localparam int ITEM_TARGET = 1850;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 4;
   localparam int HOLDOFF_LEN = 60;

   typedef struct {
      proc_state_type    state_a;
      proc_state_type    state_b;
      logic [STAT_W-1:0] ready_a;
      logic [STAT_W-1:0] ready_b;
      logic [STAT_W-1:0] busy;
      logic [STAT_W-1:0] span;
      logic              finished;
   } sched_result_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;
   logic                      req_valid   = 1'b0;
   logic                      req_restart = 1'b0;
   logic                      rsp_stall   = 1'b0;
   logic                      req_stall;
   logic                      rsp_valid;
   logic [1:0]                rsp_state_a;
   logic [1:0]                rsp_state_b;
   logic [STAT_W-1:0]         rsp_ready_ticks_a;
   logic [STAT_W-1:0]         rsp_ready_ticks_b;
   logic [STAT_W-1:0]         rsp_busy_ticks;
   logic [STAT_W-1:0]         rsp_run_length;
   logic                      rsp_finished;

   logic             pending_restarts[$];
   sched_result_type expected_ticks[$];
   int               items_sent   = 0;
   int               errors       = 0;
   int               cycle_count  = 0;
   int               rsp_beats    = 0;
   int               holdoff_left = 0;
   logic             calm         = 1'b0;

   // programmed configuration
   policy_mode_type      cfg_mode;
   logic [7:0]           cfg_quantum;
   logic [BURST_W-1:0]   cfg_p1_first, cfg_p1_io, cfg_p1_second;
   logic [BURST_W-1:0]   cfg_p2_first, cfg_p2_io, cfg_p2_second;

   // tracked scheduler state
   proc_state_type       p1_state, p2_state;
   logic [BURST_W-1:0]   p1_cpu, p1_io, p2_cpu, p2_io;
   logic [15:0]          quantum_left;
   logic [STAT_W-1:0]    p1_ready_ticks, p2_ready_ticks, busy_total, span_total;

   two_process_cpu_scheduler_core #(
      .BURST_BITS(BURST_W),
      .STAT_BITS (STAT_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_state_a      (rsp_state_a),
      .rsp_state_b      (rsp_state_b),
      .rsp_ready_ticks_a(rsp_ready_ticks_a),
      .rsp_ready_ticks_b(rsp_ready_ticks_b),
      .rsp_busy_ticks   (rsp_busy_ticks),
      .rsp_run_length   (rsp_run_length),
      .rsp_finished     (rsp_finished)
   );

   always #10 clock = ~clock;

   function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void load_run();
      p1_state       = ST_READY;
      p2_state       = ST_READY;
      p1_cpu         = cfg_p1_first;
      p1_io          = cfg_p1_io;
      p2_cpu         = cfg_p2_first;
      p2_io          = cfg_p2_io;
      quantum_left   = '0;
      p1_ready_ticks = '0;
      p2_ready_ticks = '0;
      busy_total     = '0;
      span_total     = '0;
   endfunction

   function automatic void step_scheduler(input logic restart);
      sched_result_type r;
      logic rr, sj;
      rr = (cfg_mode == MODE_RR);
      sj = (cfg_mode == MODE_SJF) || (cfg_mode == MODE_PSJF);
      if (restart) load_run();
      if (!(p1_state == ST_DONE && p2_state == ST_DONE)) begin
         if (p1_state == ST_RUN && p1_cpu == 0) begin
            p1_state = (p1_io == 0) ? ST_DONE : ST_WAIT;
         end else if (p2_state == ST_RUN && p2_cpu == 0) begin
            p2_state = (p2_io == 0) ? ST_DONE : ST_WAIT;
         end
         if (p1_state == ST_WAIT && p1_io == 0) begin
            p1_state = ST_READY;
            p1_cpu   = cfg_p1_second;
         end
         if (p2_state == ST_WAIT && p2_io == 0) begin
            p2_state = ST_READY;
            p2_cpu   = cfg_p2_second;
         end
         if (rr) begin
            if (p1_state == ST_RUN && quantum_left == 0 && p2_state == ST_READY) begin
               p2_state     = ST_RUN;
               p1_state     = ST_READY;
               quantum_left = {8'h00, cfg_quantum};
            end
            if (p2_state == ST_RUN && quantum_left == 0 && p1_state == ST_READY) begin
               p1_state     = ST_RUN;
               p2_state     = ST_READY;
               quantum_left = {8'h00, cfg_quantum};
            end
         end
         if (p1_state == ST_READY && p2_state == ST_READY) begin
            if (sj && p2_cpu < p1_cpu) p2_state = ST_RUN;
            else p1_state = ST_RUN;
            if (rr) quantum_left = {8'h00, cfg_quantum};
         end else if (p1_state == ST_READY && p2_state != ST_RUN) begin
            p1_state = ST_RUN;
            if (rr) quantum_left = {8'h00, cfg_quantum};
         end else if (p2_state == ST_READY && p1_state != ST_RUN) begin
            p2_state = ST_RUN;
            if (rr) quantum_left = {8'h00, cfg_quantum};
         end else if (cfg_mode == MODE_PSJF) begin
            if (p1_state == ST_READY && p1_cpu < p2_cpu) begin
               p1_state = ST_RUN;
               p2_state = ST_READY;
            end else if (p2_state == ST_READY && p2_cpu < p1_cpu) begin
               p2_state = ST_RUN;
               p1_state = ST_READY;
            end
         end
         if (p1_state == ST_READY) p1_ready_ticks = sat_inc(p1_ready_ticks);
         if (p2_state == ST_READY) p2_ready_ticks = sat_inc(p2_ready_ticks);
         if (p1_state == ST_RUN) busy_total = sat_inc(busy_total);
         if (p2_state == ST_RUN) busy_total = sat_inc(busy_total);
         if (p1_state != ST_DONE || p2_state != ST_DONE) span_total = sat_inc(span_total);
         if (rr) quantum_left = quantum_left - 1'b1;
         if (p1_state == ST_RUN) p1_cpu = p1_cpu - 1'b1;
         if (p1_state == ST_WAIT) p1_io = p1_io - 1'b1;
         if (p2_state == ST_RUN) p2_cpu = p2_cpu - 1'b1;
         if (p2_state == ST_WAIT) p2_io = p2_io - 1'b1;
      end
      r.state_a  = p1_state;
      r.state_b  = p2_state;
      r.ready_a  = p1_ready_ticks;
      r.ready_b  = p2_ready_ticks;
      r.busy     = busy_total;
      r.span     = span_total;
      r.finished = (p1_state == ST_DONE && p2_state == ST_DONE);
      expected_ticks.push_back(r);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch at beat %0d, %s: got %0d, expected %0d",
               rsp_beats, field, got, want);
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   task automatic check_tick();
      sched_result_type want;
      if (expected_ticks.size() == 0) begin
         report_mismatch("unexpected beat", 32'd1, 32'd0);
      end else begin
         want = expected_ticks.pop_front();
         compare_field("state_a", rsp_state_a, want.state_a);
         compare_field("state_b", rsp_state_b, want.state_b);
         compare_field("ready_ticks_a", rsp_ready_ticks_a, want.ready_a);
         compare_field("ready_ticks_b", rsp_ready_ticks_b, want.ready_b);
         compare_field("busy_ticks", rsp_busy_ticks, want.busy);
         compare_field("run_length", rsp_run_length, want.span);
         compare_field("finished", rsp_finished, want.finished);
      end
   endtask

   // driver: hold a stalled beat, otherwise advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
      end else begin
         if (req_valid && !req_stall) step_scheduler(req_restart);
         if (!req_valid || !req_stall) begin
            if (pending_restarts.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
               req_valid   <= 1'b1;
               req_restart <= pending_restarts.pop_front();
            end else begin
               req_valid   <= 1'b0;
               req_restart <= 1'($urandom_range(1));
            end
         end
      end
   end

   // monitor: check each response beat, stall at random or hold off long
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         holdoff_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_tick();
            rsp_beats <= rsp_beats + 1;
         end
         if (holdoff_left != 0) begin
            rsp_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
         end else if (rsp_valid && !rsp_stall && (rsp_beats == 400 || rsp_beats == 1400)) begin
            rsp_stall    <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 9);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_POLICY_MODE:  cfg_mode      = policy_mode_type'(data[1:0]);
         CSR_TIME_SLICE:   cfg_quantum   = data[7:0];
         CSR_FIRST_CPU_A:  cfg_p1_first  = data;
         CSR_IO_A:         cfg_p1_io     = data;
         CSR_SECOND_CPU_A: cfg_p1_second = data;
         CSR_FIRST_CPU_B:  cfg_p2_first  = data;
         CSR_IO_B:         cfg_p2_io     = data;
         CSR_SECOND_CPU_B: cfg_p2_second = data;
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || req_valid || expected_ticks.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic run_phase(input policy_mode_type mode, input logic [7:0] quantum,
                            input logic [BURST_W-1:0] f1, i1, s1, f2, i2, s2,
                            input int n, input logic first_restart, input int restart_pct);
      drain();
      write_csr(CSR_POLICY_MODE, CSR_DATA_BITS'(mode));
      write_csr(CSR_TIME_SLICE, CSR_DATA_BITS'(quantum));
      write_csr(CSR_FIRST_CPU_A, f1);
      write_csr(CSR_IO_A, i1);
      write_csr(CSR_SECOND_CPU_A, s1);
      write_csr(CSR_FIRST_CPU_B, f2);
      write_csr(CSR_IO_B, i2);
      write_csr(CSR_SECOND_CPU_B, s2);
      @(negedge clock);
      pending_restarts.push_back(first_restart);
      for (int k = 1; k < n; k++)
         pending_restarts.push_back($urandom_range(99) < restart_pct);
      items_sent += n;
   endtask

   function automatic logic [BURST_W-1:0] rand_burst();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 7) return '1;
      if (r < 14) return BURST_W'($urandom_range(1023));
      return BURST_W'($urandom_range(1, 12));
   endfunction

   initial begin
      int                 est;
      int                 r;
      logic [7:0]         q;
      logic [BURST_W-1:0] f1, i1, s1, f2, i2, s2;
      cfg_mode      = MODE_FCFS;
      cfg_quantum   = 8'd1;
      cfg_p1_first  = 1;
      cfg_p1_io     = 1;
      cfg_p1_second = 1;
      cfg_p2_first  = 1;
      cfg_p2_io     = 1;
      cfg_p2_second = 1;
      load_run();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, run stops before both processes finish
      for (int k = 0; k < 4; k++) pending_restarts.push_back(1'b0);
      items_sent += 4;
      // shorter second job goes first
      run_phase(MODE_SJF, 8'd1, 3, 1, 1, 1, 1, 1, 4, 1'b1, 0);
      // second burst of the shorter job preempts
      run_phase(MODE_PSJF, 8'd1, 5, 1, 1, 1, 1, 1, 5, 1'b1, 0);
      // zero quantum, zero CPU burst, zero IO burst
      run_phase(MODE_RR, 8'd0, 0, 1, 1, 2, 0, 1, 5, 1'b1, 0);
      run_phase(MODE_RR, 8'd255, '1, '1, '1, '1, '1, '1, 3, 1'b1, 0);
      run_phase(MODE_FCFS, 8'd1, 1, 1, 1, 1, 1, 1, 4, 1'b1, 0);

      while (items_sent < ITEM_TARGET) begin
         calm = (items_sent >= 700 && items_sent < 1000);
         r = $urandom_range(99);
         if (r < 5) q = 8'd0;
         else if (r < 10) q = 8'd255;
         else q = 8'($urandom_range(1, 6));
         f1 = rand_burst();
         i1 = rand_burst();
         s1 = rand_burst();
         f2 = rand_burst();
         i2 = rand_burst();
         s2 = rand_burst();
         est = f1 + i1 + s1 + f2 + i2 + s2 + $urandom_range(1, 6);
         if (est > 160) est = $urandom_range(60, 160);
         run_phase(policy_mode_type'($urandom_range(3)), q, f1, i1, s1, f2, i2, s2,
                   est, $urandom_range(9) != 0, 2);
      end
      calm = 1'b0;
      drain();

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
